/* src/cds_pkg.sv */
package cds_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned R4W    = 2;
  localparam int unsigned R100W  = 7;
  localparam int unsigned R400W  = 9;

  localparam logic [ModeW-1:0] ModeLoad = 2'd0;
  localparam logic [ModeW-1:0] ModeAdd  = 2'd1;
  localparam logic [ModeW-1:0] ModeBack = 2'd2;

  localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;
  localparam logic [DayW-1:0]   LeapFebDays   = 5'd29;
  localparam logic [DayW-1:0]   DecemberDays  = 5'd31;
  localparam logic [R100W-1:0]  CenturyLast   = 7'd99;
  localparam logic [R400W-1:0]  QuadCentLast  = 9'd399;
  localparam logic [YearW-1:0]  YearsPerCent  = 14'd100;
  localparam logic [YearW-1:0]  YearsPerQuad  = 14'd400;

  localparam logic [DayW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Gregorian rule from the remainders of the year by 4, 100 and 400.
  function automatic logic is_leap(logic [R4W-1:0] r4, logic [R100W-1:0] r100,
                                   logic [R400W-1:0] r400);
    return (r4 == '0) && ((r100 != '0) || (r400 == '0));
  endfunction

  // Month length; a month outside 1..12 reads as January.
  function automatic logic [DayW-1:0] days_in(logic [MonthW-1:0] month, logic leap);
    logic [3:0] idx;
    idx = (month >= 4'd1 && month <= MonthsPerYear) ? month - 4'd1 : 4'd0;
    if (idx == 4'd1 && leap) begin
      return LeapFebDays;
    end
    return MonthLen[idx];
  endfunction

endpackage

/* src/calendar_date_stepper.sv */
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   mode_i, load_day_i, load_month_i,
//                                                load_year_i, add_days_i
// out       output     out_valid_o / out_ready_i date_day_o, date_month_o, date_year_o,
//                                                leap_flag_o, overflow_flag_o
//
// Each item gives exactly one result item. A step back or an unused mode goes from the idle
// state straight to the finish state. A load runs the shared subtractor, which reduces the year
// by 400 and then by 100, one subtraction per cycle, and then checks the date. An add steps
// through the months in the add state, one month boundary at a time, until the days run out.
// Reset holds 1 January of year 1. The input is not ready while an item is in progress;
// a finished result waits in the output register while the next item is taken, and an
// item stalls in its last cycle while the previous result has not yet been taken.
module calendar_date_stepper #(
  parameter int unsigned ADD_WIDTH  = 16,
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cds_pkg::ModeW-1:0]     mode_i,
  input  logic [cds_pkg::DayW-1:0]      load_day_i,
  input  logic [cds_pkg::MonthW-1:0]    load_month_i,
  input  logic [cds_pkg::YearW-1:0]     load_year_i,
  input  logic [ADD_WIDTH-1:0]          add_days_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cds_pkg::DayW-1:0]      date_day_o,
  output logic [cds_pkg::MonthW-1:0]    date_month_o,
  output logic [cds_pkg::YearW-1:0]     date_year_o,
  output logic                          leap_flag_o,
  output logic                          overflow_flag_o
);
  import cds_pkg::*;

  // The working counter holds the held day plus the full add count.
  localparam int unsigned CntW  = ADD_WIDTH + 1;
  // One extra bit so that the year just past the limit can be seen.
  localparam int unsigned WYearW = YearW + 1;
  localparam logic [32:0] AddLimit = 33'((YEAR_LIMIT + 1) * 366);
  localparam logic [WYearW-1:0] YearMax = WYearW'(YEAR_LIMIT);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRem400 = 3'd1;
  localparam logic [2:0] StRem100 = 3'd2;
  localparam logic [2:0] StCheck  = 3'd3;
  localparam logic [2:0] StAdd    = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0] state_q, state_d;

  // The committed date and the remainders of its year.
  logic [DayW-1:0]   held_day_q, held_day_d;
  logic [MonthW-1:0] held_month_q, held_month_d;
  logic [YearW-1:0]  held_year_q, held_year_d;
  logic [R4W-1:0]    held_r4_q, held_r4_d;
  logic [R100W-1:0]  held_r100_q, held_r100_d;
  logic [R400W-1:0]  held_r400_q, held_r400_d;

  // The date being worked on for the current item.
  logic [DayW-1:0]   w_day_q, w_day_d;
  logic [MonthW-1:0] w_month_q, w_month_d;
  logic [WYearW-1:0] w_year_q, w_year_d;
  logic [R4W-1:0]    w_r4_q, w_r4_d;
  logic [R100W-1:0]  w_r100_q, w_r100_d;
  logic [R400W-1:0]  w_r400_q, w_r400_d;
  logic [CntW-1:0]   w_cnt_q, w_cnt_d;
  logic [YearW-1:0]  w_rem_q, w_rem_d;
  logic              w_ovf_q, w_ovf_d;

  logic              out_valid_q, out_valid_d;
  logic [DayW-1:0]   out_day_q, out_day_d;
  logic [MonthW-1:0] out_month_q, out_month_d;
  logic [YearW-1:0]  out_year_q, out_year_d;
  logic              out_leap_q, out_leap_d;
  logic              out_ovf_q, out_ovf_d;

  logic              accept;
  logic              w_leap;
  logic              held_leap;
  logic [DayW-1:0]   w_dim;
  logic [YearW-1:0]  rem_sub;
  logic [YearW-1:0]  rem_step;
  logic              rem_ge;
  logic              load_bad;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign w_leap    = is_leap(w_r4_q, w_r100_q, w_r400_q);
  assign held_leap = is_leap(held_r4_q, held_r100_q, held_r400_q);
  assign w_dim     = days_in(w_month_q, w_leap);

  // The shared subtractor reduces the loaded year to its remainders.
  assign rem_step = (state_q == StRem400) ? YearsPerQuad : YearsPerCent;
  assign rem_ge   = (w_rem_q >= rem_step);
  assign rem_sub  = w_rem_q - rem_step;

  assign load_bad = (w_year_q == '0) || (w_year_q > YearMax) ||
                    (w_month_q == '0) || (w_month_q > MonthsPerYear) ||
                    (w_day_q == '0) || (w_day_q > w_dim);

  always_comb begin
    state_d      = state_q;
    held_day_d   = held_day_q;
    held_month_d = held_month_q;
    held_year_d  = held_year_q;
    held_r4_d    = held_r4_q;
    held_r100_d  = held_r100_q;
    held_r400_d  = held_r400_q;
    w_day_d      = w_day_q;
    w_month_d    = w_month_q;
    w_year_d     = w_year_q;
    w_r4_d       = w_r4_q;
    w_r100_d     = w_r100_q;
    w_r400_d     = w_r400_q;
    w_cnt_d      = w_cnt_q;
    w_rem_d      = w_rem_q;
    w_ovf_d      = w_ovf_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_day_d    = out_day_q;
    out_month_d  = out_month_q;
    out_year_d   = out_year_q;
    out_leap_d   = out_leap_q;
    out_ovf_d    = out_ovf_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          // Start from the held date; each mode then changes what it needs.
          w_day_d   = held_day_q;
          w_month_d = held_month_q;
          w_year_d  = WYearW'(held_year_q);
          w_r4_d    = held_r4_q;
          w_r100_d  = held_r100_q;
          w_r400_d  = held_r400_q;
          w_ovf_d   = 1'b0;
          state_d   = StFinish;
          case (mode_i)
            ModeLoad: begin
              w_day_d   = load_day_i;
              w_month_d = load_month_i;
              w_year_d  = WYearW'(load_year_i);
              w_rem_d   = load_year_i;
              state_d   = StRem400;
            end
            ModeAdd: begin
              if (33'(add_days_i) > AddLimit) begin
                w_ovf_d = 1'b1;
              end else begin
                w_cnt_d = CntW'(held_day_q) + CntW'(add_days_i);
                state_d = StAdd;
              end
            end
            ModeBack: begin
              if (held_day_q > 5'd1) begin
                w_day_d = held_day_q - 5'd1;
              end else if (held_month_q > 4'd1) begin
                w_month_d = held_month_q - 4'd1;
                w_day_d   = days_in(held_month_q - 4'd1, held_leap);
              end else if (held_year_q > 14'd1) begin
                w_year_d  = WYearW'(held_year_q) - 15'd1;
                w_r4_d    = held_r4_q - 2'd1;
                w_r100_d  = (held_r100_q == '0) ? CenturyLast : held_r100_q - 7'd1;
                w_r400_d  = (held_r400_q == '0) ? QuadCentLast : held_r400_q - 9'd1;
                w_month_d = MonthsPerYear;
                w_day_d   = DecemberDays;
              end else begin
                w_ovf_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StRem400: begin
        if (rem_ge) begin
          w_rem_d = rem_sub;
        end else begin
          w_r400_d = w_rem_q[R400W-1:0];
          state_d  = StRem100;
        end
      end
      StRem100: begin
        if (rem_ge) begin
          w_rem_d = rem_sub;
        end else begin
          w_r100_d = w_rem_q[R100W-1:0];
          w_r4_d   = w_year_q[R4W-1:0];
          state_d  = StCheck;
        end
      end
      StCheck: begin
        w_ovf_d = load_bad;
        state_d = StFinish;
      end
      StAdd: begin
        // One month boundary per cycle.
        if (w_cnt_q > CntW'(w_dim)) begin
          w_cnt_d = w_cnt_q - CntW'(w_dim);
          if (w_month_q == MonthsPerYear) begin
            w_month_d = 4'd1;
            w_year_d  = w_year_q + 15'd1;
            w_r4_d    = w_r4_q + 2'd1;
            w_r100_d  = (w_r100_q >= CenturyLast) ? '0 : w_r100_q + 7'd1;
            w_r400_d  = (w_r400_q >= QuadCentLast) ? '0 : w_r400_q + 9'd1;
            if (w_year_q + 15'd1 > YearMax) begin
              w_ovf_d = 1'b1;
              state_d = StFinish;
            end
          end else begin
            w_month_d = w_month_q + 4'd1;
          end
        end else begin
          w_day_d = w_cnt_q[DayW-1:0];
          state_d = StFinish;
        end
      end
      StFinish: begin
        // A refused step keeps the held date and reports it unchanged.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ovf_d   = w_ovf_q;
          if (w_ovf_q) begin
            out_day_d   = held_day_q;
            out_month_d = held_month_q;
            out_year_d  = held_year_q;
            out_leap_d  = held_leap;
          end else begin
            held_day_d   = w_day_q;
            held_month_d = w_month_q;
            held_year_d  = w_year_q[YearW-1:0];
            held_r4_d    = w_r4_q;
            held_r100_d  = w_r100_q;
            held_r400_d  = w_r400_q;
            out_day_d    = w_day_q;
            out_month_d  = w_month_q;
            out_year_d   = w_year_q[YearW-1:0];
            out_leap_d   = w_leap;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      held_day_q   <= 5'd1;
      held_month_q <= 4'd1;
      held_year_q  <= 14'd1;
      held_r4_q    <= 2'd1;
      held_r100_q  <= 7'd1;
      held_r400_q  <= 9'd1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_day_q   <= held_day_d;
      held_month_q <= held_month_d;
      held_year_q  <= held_year_d;
      held_r4_q    <= held_r4_d;
      held_r100_q  <= held_r100_d;
      held_r400_q  <= held_r400_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_day_q     <= w_day_d;
    w_month_q   <= w_month_d;
    w_year_q    <= w_year_d;
    w_r4_q      <= w_r4_d;
    w_r100_q    <= w_r100_d;
    w_r400_q    <= w_r400_d;
    w_cnt_q     <= w_cnt_d;
    w_rem_q     <= w_rem_d;
    w_ovf_q     <= w_ovf_d;
    out_day_q   <= out_day_d;
    out_month_q <= out_month_d;
    out_year_q  <= out_year_d;
    out_leap_q  <= out_leap_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign date_day_o      = out_day_q;
  assign date_month_o    = out_month_q;
  assign date_year_o     = out_year_q;
  assign leap_flag_o     = out_leap_q;
  assign overflow_flag_o = out_ovf_q;

endmodule
